### hdl/slx_pkg.sv
// Shared types, character codes and token kinds for the script token lexer.
`timescale 1ns / 1ps

package slx_pkg;

    // Tokens caused by one character at most, and depth of the bundle queue
    localparam int unsigned NRES   = 3;
    localparam int unsigned QDEPTH = 4;

    // Width of the position counter unless the top level is told otherwise
    localparam int unsigned POS_BITS_DEFAULT = 16;

    // Characters with a role of their own
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    // Token kinds
    localparam logic [7:0] KIND_UNDEF = 8'd0;
    localparam logic [7:0] KIND_IDENT = 8'd128;
    localparam logic [7:0] KIND_LE    = 8'd129;
    localparam logic [7:0] KIND_GE    = 8'd130;
    localparam logic [7:0] KIND_EQ    = 8'd131;
    localparam logic [7:0] KIND_AND   = 8'd132;
    localparam logic [7:0] KIND_OR    = 8'd133;
    localparam logic [7:0] KIND_NOT   = 8'd134;
    localparam logic [7:0] KIND_OF    = 8'd135;
    localparam logic [7:0] KIND_IN    = 8'd136;
    localparam logic [7:0] KIND_NUM   = 8'd137;
    localparam logic [7:0] KIND_RANGE = 8'd138;
    localparam logic [7:0] KIND_STR   = 8'd139;
    localparam logic [7:0] KIND_END   = 8'd140;

    // Keyword spellings, first character in the low byte
    localparam logic [15:0] WORD_OR  = 16'h726F;   // "or"
    localparam logic [15:0] WORD_IN  = 16'h6E69;   // "in"
    localparam logic [15:0] WORD_OF  = 16'h666F;   // "of"
    localparam logic [23:0] WORD_AND = 24'h646E61; // "and"
    localparam logic [23:0] WORD_NOT = 24'h746F6E; // "not"

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING,
        MODE_SYMHELD
    } mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_req_t;

    typedef struct packed {
        logic [7:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
    } tok_t;

    typedef struct packed {
        logic [7:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } token_req_t;

    // All tokens caused by one character, count from 1 to NRES
    typedef struct packed {
        logic [1:0]           count;
        tok_t [NRES-1:0]      toks;
    } bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_single_symbol(input logic [7:0] c);
        return c inside {8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E,
                         8'h2A, 8'h2B, 8'h2D, 8'h2F, 8'h3D, 8'h3B, 8'h2C};
    endfunction

    // Keyword lookup from the word length and its first three characters
    function automatic logic [7:0] word_kind(input logic [15:0] len,
                                             input logic [23:0] prefix);
        logic [7:0] k;
        k = KIND_IDENT;
        if (len == 16'd2) begin
            if (prefix[15:0] == WORD_OR)
                k = KIND_OR;
            else if (prefix[15:0] == WORD_IN)
                k = KIND_IN;
            else if (prefix[15:0] == WORD_OF)
                k = KIND_OF;
        end
        else if (len == 16'd3) begin
            if (prefix == WORD_AND)
                k = KIND_AND;
            else if (prefix == WORD_NOT)
                k = KIND_NOT;
        end
        return k;
    endfunction

endpackage

### hdl/slx_front.sv
// Front end: takes one character a cycle while the queue has room, runs the scan state, packs its tokens.
`timescale 1ns / 1ps

module slx_front
    import slx_pkg::*;
#(
    parameter int unsigned POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  char_req_t char_data,
    input  logic      push_space,
    output logic      push_valid,
    output bundle_t   push_bundle
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] begin_reg, begin_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [15:0]         line_reg, line_next;
    logic [23:0]         prefix_reg, prefix_next;
    logic                range_reg, range_next;
    logic [7:0]          quote_reg, quote_next;
    logic [7:0]          held_reg, held_next;
    logic                held_cr_reg, held_cr_next;

    logic                accept;
    logic [7:0]          c;
    logic [POS_BITS-1:0] pos_inc;
    logic [15:0]         line_mid;
    logic [15:0]         len_cur;
    logic [15:0]         len_flush;
    logic                do_start;
    tok_t                cand [4];
    logic [3:0]          cand_v;
    logic [1:0]          fill;

    // Span between two offsets, saturated to 16 bits
    function automatic logic [15:0] span(input logic [POS_BITS-1:0] a,
                                         input logic [POS_BITS-1:0] b);
        logic [POS_BITS-1:0] d;
        logic [31:0]         d32;
        d   = (b > a) ? b - a : '0;
        d32 = 32'(d);
        return (d32 > 32'h0000_FFFF) ? 16'hFFFF : d32[15:0];
    endfunction

    function automatic logic [15:0] low16(input logic [POS_BITS-1:0] p);
        logic [31:0] p32;
        p32 = 32'(p);
        return p32[15:0];
    endfunction

    function automatic logic [15:0] line_inc(input logic [15:0] l);
        return (l != 16'hFFFF) ? l + 16'd1 : l;
    endfunction

    assign accept     = char_valid && char_ready;
    assign char_ready = push_space;
    assign c          = char_data.char_code;
    assign pos_inc    = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    assign len_cur    = span(begin_reg, pos_reg);

    // Scan state update and token candidates in emission order
    always_comb
    begin
        mode_next    = mode_reg;
        begin_next   = begin_reg;
        pos_next     = pos_reg;
        prefix_next  = prefix_reg;
        range_next   = range_reg;
        quote_next   = quote_reg;
        held_next    = held_reg;
        held_cr_next = held_cr_reg;
        line_mid     = line_reg;
        do_start     = 1'b0;
        len_flush    = '0;
        for (int i = 0; i < 4; i++)
        begin
            cand[i]   = '0;
            cand_v[i] = 1'b0;
        end
        cand[0].line_number = line_reg;
        cand[1].line_number = line_reg;

        // Mode of the open token decides what this character does
        case (mode_reg)
            MODE_COMMENT:
            begin
                if (c == CH_LF)
                begin
                    line_mid  = line_inc(line_reg);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (is_letter(c) || is_numeral(c))
                begin
                    if (len_cur < 16'd3)
                    begin
                        case (len_cur[1:0])
                            2'd0:    prefix_next[7:0]   = prefix_reg[7:0] | c;
                            2'd1:    prefix_next[15:8]  = prefix_reg[15:8] | c;
                            default: prefix_next[23:16] = prefix_reg[23:16] | c;
                        endcase
                    end
                end
                else
                begin
                    cand_v[0]             = 1'b1;
                    cand[0].token_kind    = word_kind(len_cur, prefix_reg);
                    cand[0].token_start   = low16(begin_reg);
                    cand[0].token_length  = len_cur;
                    do_start              = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (c == CH_COLON)
                    range_next = 1'b1;
                else if (!is_numeral(c) && c != CH_DOT)
                begin
                    cand_v[0]            = 1'b1;
                    cand[0].token_kind   = range_reg ? KIND_RANGE : KIND_NUM;
                    cand[0].token_start  = low16(begin_reg);
                    cand[0].token_length = len_cur;
                    do_start             = 1'b1;
                end
            end
            MODE_STRING:
            begin
                held_cr_next = 1'b0;
                if (held_cr_reg && c == CH_LF)
                begin
                    // CR LF ends the string as an undefined token before the CR
                    cand_v[0]            = 1'b1;
                    cand[0].token_kind   = KIND_UNDEF;
                    cand[0].token_start  = low16(begin_reg);
                    cand[0].token_length = (len_cur != 16'd0) ? len_cur - 16'd1 : len_cur;
                    do_start             = 1'b1;
                end
                else if (c == quote_reg)
                begin
                    cand_v[0]            = 1'b1;
                    cand[0].token_kind   = KIND_STR;
                    cand[0].token_start  = low16(begin_reg);
                    cand[0].token_length = span(begin_reg, pos_inc);
                    mode_next            = MODE_IDLE;
                end
                else if (c == CH_CR)
                    held_cr_next = 1'b1;
            end
            MODE_SYMHELD:
            begin
                cand_v[0]           = 1'b1;
                cand[0].token_start = low16(begin_reg);
                if (c == CH_EQ)
                begin
                    cand[0].token_length = 16'd2;
                    if (held_reg == CH_LT)
                        cand[0].token_kind = KIND_LE;
                    else if (held_reg == CH_GT)
                        cand[0].token_kind = KIND_GE;
                    else
                        cand[0].token_kind = KIND_EQ;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    cand[0].token_kind   = held_reg;
                    cand[0].token_length = 16'd1;
                    do_start             = 1'b1;
                end
            end
            default:
                do_start = 1'b1;
        endcase

        // Scan the character from the idle mode
        if (do_start)
        begin
            mode_next = MODE_IDLE;
            if (c == CH_HASH)
                mode_next = MODE_COMMENT;
            else if (c == CH_LF)
                line_mid = line_inc(line_reg);
            else if (is_letter(c))
            begin
                mode_next   = MODE_WORD;
                begin_next  = pos_reg;
                prefix_next = {16'd0, c};
            end
            else if (is_numeral(c) || c == CH_COLON)
            begin
                mode_next  = MODE_NUMBER;
                begin_next = pos_reg;
                range_next = (c == CH_COLON);
            end
            else if (c == CH_SQUOTE || c == CH_DQUOTE)
            begin
                mode_next    = MODE_STRING;
                begin_next   = pos_reg;
                quote_next   = c;
                held_cr_next = 1'b0;
            end
            else if (c == CH_LT || c == CH_GT || c == CH_EQ)
            begin
                mode_next  = MODE_SYMHELD;
                begin_next = pos_reg;
                held_next  = c;
            end
            else if (is_single_symbol(c))
            begin
                cand_v[1]            = 1'b1;
                cand[1].token_kind   = c;
                cand[1].token_start  = low16(pos_reg);
                cand[1].token_length = 16'd1;
            end
        end

        // End of text: flush the open token, add the end token, restart
        if (char_data.last_char)
        begin
            len_flush            = span(begin_next, pos_inc);
            cand[2].token_start  = low16(begin_next);
            cand[2].token_length = len_flush;
            cand[2].line_number  = line_mid;
            case (mode_next)
                MODE_WORD:
                begin
                    cand_v[2]          = 1'b1;
                    cand[2].token_kind = word_kind(len_flush, prefix_next);
                end
                MODE_NUMBER:
                begin
                    cand_v[2]          = 1'b1;
                    cand[2].token_kind = range_next ? KIND_RANGE : KIND_NUM;
                end
                MODE_STRING:
                begin
                    cand_v[2]          = 1'b1;
                    cand[2].token_kind = KIND_UNDEF;
                end
                MODE_SYMHELD:
                begin
                    cand_v[2]            = 1'b1;
                    cand[2].token_kind   = held_next;
                    cand[2].token_length = 16'd1;
                end
                default:
                    cand_v[2] = 1'b0;
            endcase
            cand_v[3]           = 1'b1;
            cand[3].token_kind  = KIND_END;
            cand[3].line_number = line_mid;

            mode_next    = MODE_IDLE;
            begin_next   = '0;
            pos_next     = '0;
            prefix_next  = '0;
            range_next   = 1'b0;
            quote_next   = '0;
            held_next    = '0;
            held_cr_next = 1'b0;
            line_next    = 16'd1;
        end
        else
        begin
            pos_next  = pos_inc;
            line_next = line_mid;
        end
    end

    // Pack the candidates into consecutive slots
    always_comb
    begin
        push_bundle = '0;
        fill        = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && fill != 2'd3)
            begin
                push_bundle.toks[fill] = cand[i];
                fill = fill + 2'd1;
            end
        end
        push_bundle.count = fill;
    end

    assign push_valid = accept && (fill != 2'd0);

    // Hold the scan state between characters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            begin_reg   <= '0;
            pos_reg     <= '0;
            line_reg    <= 16'd1;
            prefix_reg  <= '0;
            range_reg   <= 1'b0;
            quote_reg   <= '0;
            held_reg    <= '0;
            held_cr_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            begin_reg   <= begin_next;
            pos_reg     <= pos_next;
            line_reg    <= line_next;
            prefix_reg  <= prefix_next;
            range_reg   <= range_next;
            quote_reg   <= quote_next;
            held_reg    <= held_next;
            held_cr_reg <= held_cr_next;
        end
    end

`ifndef SYNTH
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_data.last_char) |=>
            (mode_reg == MODE_IDLE && pos_reg == '0 && line_reg == 16'd1))
        else $error("scan state not restarted after end of text");

    a_last_pushes_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_data.last_char) |->
            (push_valid && push_bundle.toks[push_bundle.count - 2'd1].token_kind == KIND_END))
        else $error("end of text without end token");
`endif

endmodule

### hdl/slx_queue.sv
// Short bundle queue between the scanning front end and the token back end.
`timescale 1ns / 1ps

module slx_queue
    import slx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  bundle_t push_bundle,
    output logic    push_space,
    output logic    head_valid,
    output bundle_t head_bundle,
    input  logic    pop
);

    localparam int unsigned PTR_W = $clog2(QDEPTH);
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    bundle_t            slots_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign push_space  = (count_reg != CNT_W'(QDEPTH));
    assign head_valid  = (count_reg != '0);
    assign head_bundle = slots_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_valid) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming bundle
    always_ff @(posedge clk)
    begin
        if (push_valid)
            slots_reg[wr_ptr_reg] <= push_bundle;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_space)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

### hdl/slx_back.sv
// Back end: unpacks queued bundles into one token request per cycle while token_ready is high.
`timescale 1ns / 1ps

module slx_back
    import slx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  bundle_t    head_bundle,
    output logic       pop,
    output logic       token_valid,
    input  logic       token_ready,
    output token_req_t token_data
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    token_req_t out_data_reg, out_data_next;
    logic       load;
    logic       run_end;
    tok_t       cur;

    assign cur     = head_bundle.toks[idx_reg];
    assign run_end = (idx_reg == head_bundle.count - 2'd1);
    assign load    = head_valid && (!out_valid_reg || token_ready);
    assign pop     = load && run_end;

    // Step through the bundle, refill the output register when it frees up
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next             = 1'b1;
            out_data_next.token_kind   = cur.token_kind;
            out_data_next.token_start  = cur.token_start;
            out_data_next.token_length = cur.token_length;
            out_data_next.line_number  = cur.line_number;
            out_data_next.last_of_run  = run_end;
            idx_next                   = run_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (token_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign token_valid = out_valid_reg;
    assign token_data  = out_data_reg;

`ifndef SYNTH
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_bundle.count != 2'd0 && idx_reg < head_bundle.count))
        else $error("bundle index beyond token count");
`endif

endmodule

### hdl/script_token_lexer.sv
// Script token lexer top level: front end, bundle queue and token back end.
// Path: a character's tokens pass the bundle queue, then the back end output register.
// Throughput: one character per cycle while the four-entry bundle queue has room.
// Output: one token per cycle from the back end register while token_ready is high;
// a character of k tokens holds it until all are out; the queue absorbs the difference.
// Reset: asynchronous, clears scan state (line count to one), queue and output.
`timescale 1ns / 1ps

module script_token_lexer
    import slx_pkg::*;
#(
    parameter int unsigned POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_req_t  char_data,
    output logic       token_valid,
    input  logic       token_ready,
    output token_req_t token_data
);

    logic    push_valid;
    logic    push_space;
    bundle_t push_bundle;
    logic    head_valid;
    bundle_t head_bundle;
    logic    pop;

    slx_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .push_space  (push_space),
        .push_valid  (push_valid),
        .push_bundle (push_bundle)
    );

    slx_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_bundle (push_bundle),
        .push_space  (push_space),
        .head_valid  (head_valid),
        .head_bundle (head_bundle),
        .pop         (pop)
    );

    slx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_bundle (head_bundle),
        .pop         (pop),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data)
    );

endmodule
